// ----- rtl/shac_pkg.sv -----
// ----------------------------------------------------------------------------
// shac_pkg: shared types, constants and functions of the SHA-256 compressor
//
// Holds the word and hash types, the initial hash, the round-constant table,
// the sigma functions and the control struct between the top and round unit.
// ----------------------------------------------------------------------------
`default_nettype none

package shac_pkg;

    // One 32-bit word and the eight words of a hash or working-variable set.
    typedef logic [31:0] word_t;
    typedef word_t [7:0] hash_t;

    localparam int NumSchedCells = 16;
    localparam int NumRounds     = 64;
    localparam int PosWidth      = $clog2(NumSchedCells);
    localparam int RoundWidth    = $clog2(NumRounds);

    // Standard initial hash, word 0 at index 0.
    localparam hash_t InitHash = {
        32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
        32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667
    };

    // Round constants.
    localparam word_t RoundK [NumRounds] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    // Control from the sequencer to the round unit.
    typedef struct packed {
        logic load;   // take the chaining value as working variables
        logic step;   // run one round
    } round_ctrl_t;

    // Round functions on the working variables.
    function automatic word_t big_sigma0(input word_t x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    // Message schedule functions.
    function automatic word_t small_sigma0(input word_t x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

`default_nettype wire

// ----- rtl/shac_msg_if.sv -----
// ----------------------------------------------------------------------------
// shac_msg_if: message word channel
//
// Carries one 32-bit message word and the chain restart flag per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface shac_msg_if;

    logic        valid;
    logic        ready;
    logic [31:0] message_word;
    logic        restart_chain;

    modport source (output valid, output message_word, output restart_chain, input ready);
    modport sink   (input valid, input message_word, input restart_chain, output ready);

endinterface

`default_nettype wire

// ----- rtl/shac_hash_if.sv -----
// ----------------------------------------------------------------------------
// shac_hash_if: hash result channel
//
// Carries the eight updated chaining words of one block per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface shac_hash_if;

    logic        valid;
    logic        ready;
    logic [31:0] hash_word0;
    logic [31:0] hash_word1;
    logic [31:0] hash_word2;
    logic [31:0] hash_word3;
    logic [31:0] hash_word4;
    logic [31:0] hash_word5;
    logic [31:0] hash_word6;
    logic [31:0] hash_word7;

    modport source (
        output valid, input ready,
        output hash_word0, output hash_word1, output hash_word2, output hash_word3,
        output hash_word4, output hash_word5, output hash_word6, output hash_word7
    );
    modport sink (
        input valid, output ready,
        input hash_word0, input hash_word1, input hash_word2, input hash_word3,
        input hash_word4, input hash_word5, input hash_word6, input hash_word7
    );

endinterface

`default_nettype wire

// ----- rtl/shac_sched_cell.sv -----
// ----------------------------------------------------------------------------
// shac_sched_cell: one cell of the message schedule chain
//
// Holds one schedule word and takes its neighbor's word on every shift.
// ----------------------------------------------------------------------------
`default_nettype none

module shac_sched_cell
    import shac_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  shift,
    input  wire word_t d,
    output word_t      q
);

    word_t word_reg;

    // The word moves one place down the chain on each shift.
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            word_reg <= d;
        end
    end

    assign q = word_reg;

endmodule

`default_nettype wire

// ----- rtl/shac_round.sv -----
// ----------------------------------------------------------------------------
// shac_round: SHA-256 round unit
//
// Holds the working variables a to h and runs one round per step, taking the
// schedule word and round constant of that round.
// ----------------------------------------------------------------------------
`default_nettype none

module shac_round
    import shac_pkg::*;
(
    input  wire logic        clk,
    input  wire round_ctrl_t ctrl,
    input  wire hash_t       init,
    input  wire word_t       w,
    input  wire word_t       k,
    output hash_t            vars
);

    hash_t vars_reg;
    hash_t vars_next;
    word_t choose;
    word_t major;
    word_t sum1;
    word_t sum2;

    // Load takes the initial value; one round: the variables shift down and a and e take the new sums.
    always_comb
    begin
        choose = (vars_reg[4] & vars_reg[5]) ^ (~vars_reg[4] & vars_reg[6]);
        major  = (vars_reg[0] & vars_reg[1]) ^ (vars_reg[0] & vars_reg[2])
               ^ (vars_reg[1] & vars_reg[2]);
        sum1   = vars_reg[7] + big_sigma1(vars_reg[4]) + choose + k + w;
        sum2   = big_sigma0(vars_reg[0]) + major;
        vars_next = vars_reg;
        if (ctrl.load)
        begin
            vars_next = init;
        end
        else if (ctrl.step)
        begin
            vars_next[7] = vars_reg[6];
            vars_next[6] = vars_reg[5];
            vars_next[5] = vars_reg[4];
            vars_next[4] = vars_reg[3] + sum1;
            vars_next[3] = vars_reg[2];
            vars_next[2] = vars_reg[1];
            vars_next[1] = vars_reg[0];
            vars_next[0] = sum1 + sum2;
        end
    end

    always_ff @(posedge clk)
    begin
        vars_reg <= vars_next;
    end

    assign vars = vars_reg;

endmodule

`default_nettype wire

// ----- rtl/sha256_block_compress.sv -----
// ----------------------------------------------------------------------------
// sha256_block_compress: SHA-256 block compression with kept chaining value
//
// Usage: the source sends a padded message on msg, one 32-bit big-endian word
// per item, sixteen items per block. restart_chain on a block's first word
// restarts the chaining value from the initial hash; elsewhere it is ignored.
// After the sixteenth word the block runs 64 rounds, one per cycle, while a
// sixteen-cell schedule chain shifts out one schedule word per round and
// takes in the next expanded word. The updated chaining value then appears
// on hash as one item of eight words (hash_word0 first in digest order).
// The hash item is registered in the add-back state that follows the rounds.
// Blocks go one at a time through the load, round and add-back states of the
// single shared round unit, so a block's words wait for the last add-back.
// msg.ready is low during the rounds and the add-back state. A waiting hash
// item is held in its output register; the next block's words are accepted
// meanwhile, and its add-back waits until the held item is taken.
// Reset sets the chaining value to the initial hash and the word position to
// the first word of a block; no hash item is pending after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_block_compress
    import shac_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    shac_msg_if.sink    msg,
    shac_hash_if.source hash
);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_ROUND,
        ST_FINAL
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    logic [PosWidth-1:0]   pos_reg;
    logic [PosWidth-1:0]   pos_next;
    logic [RoundWidth-1:0] rnd_reg;
    logic [RoundWidth-1:0] rnd_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    hash_t                 chain_reg;
    hash_t                 chain_next;
    hash_t                 hash_reg;
    hash_t                 sum_hash;

    logic        msg_acc;
    logic        out_free;
    logic        finish;
    logic        sched_shift;
    word_t       sched_tail;
    word_t       sched_q [NumSchedCells];
    round_ctrl_t round_ctrl;
    hash_t       work_vars;

    assign msg.ready = (state_reg == ST_LOAD);
    assign msg_acc   = msg.valid && (state_reg == ST_LOAD);
    assign out_free  = !out_valid_reg || hash.ready;
    assign finish    = (state_reg == ST_FINAL) && out_free;

    // Schedule chain: words enter at the top cell and reach cell 0 in order.
    assign sched_shift = msg_acc || (state_reg == ST_ROUND);
    assign sched_tail  = (state_reg == ST_LOAD) ? msg.message_word
                       : small_sigma1(sched_q[NumSchedCells-2]) + sched_q[NumSchedCells-7]
                         + small_sigma0(sched_q[1]) + sched_q[0];

    for (genvar i = 0; i < NumSchedCells; i++)
    begin : g_sched
        if (i == NumSchedCells - 1)
        begin : g_top
            shac_sched_cell u_cell (
                .clk   (clk),
                .shift (sched_shift),
                .d     (sched_tail),
                .q     (sched_q[i])
            );
        end
        else
        begin : g_mid
            shac_sched_cell u_cell (
                .clk   (clk),
                .shift (sched_shift),
                .d     (sched_q[i+1]),
                .q     (sched_q[i])
            );
        end
    end

    // Round unit: loaded as the last word of a block is accepted.
    assign round_ctrl.load = msg_acc && (pos_reg == PosWidth'(NumSchedCells - 1));
    assign round_ctrl.step = (state_reg == ST_ROUND);

    shac_round u_round (
        .clk  (clk),
        .ctrl (round_ctrl),
        .init (chain_reg),
        .w    (sched_q[0]),
        .k    (RoundK[rnd_reg]),
        .vars (work_vars)
    );

    // Add the working variables back into the chaining value.
    always_comb
    begin
        for (int j = 0; j < 8; j++)
        begin
            sum_hash[j] = chain_reg[j] + work_vars[j];
        end
    end

    // Sequencer next state.
    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        rnd_next       = rnd_reg;
        chain_next     = chain_reg;
        out_valid_next = out_valid_reg && !hash.ready;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (msg_acc)
                begin
                    pos_next = pos_reg + 1'b1;
                    if ((pos_reg == '0) && msg.restart_chain)
                    begin
                        chain_next = InitHash;
                    end
                    if (round_ctrl.load)
                    begin
                        rnd_next   = '0;
                        state_next = ST_ROUND;
                    end
                end
            end
            ST_ROUND:
            begin
                rnd_next = rnd_reg + 1'b1;
                if (rnd_reg == RoundWidth'(NumRounds - 1))
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                if (out_free)
                begin
                    chain_next     = sum_hash;
                    out_valid_next = 1'b1;
                    state_next     = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            pos_reg       <= '0;
            rnd_reg       <= '0;
            out_valid_reg <= 1'b0;
            chain_reg     <= InitHash;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            rnd_reg       <= rnd_next;
            out_valid_reg <= out_valid_next;
            chain_reg     <= chain_next;
        end
    end

    // Output register for the hash item.
    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            hash_reg <= sum_hash;
        end
    end

    assign hash.valid      = out_valid_reg;
    assign hash.hash_word0 = hash_reg[0];
    assign hash.hash_word1 = hash_reg[1];
    assign hash.hash_word2 = hash_reg[2];
    assign hash.hash_word3 = hash_reg[3];
    assign hash.hash_word4 = hash_reg[4];
    assign hash.hash_word5 = hash_reg[5];
    assign hash.hash_word6 = hash_reg[6];
    assign hash.hash_word7 = hash_reg[7];

endmodule

`default_nettype wire

// ----- rtl/shac_check.sv -----
// ----------------------------------------------------------------------------
// shac_check: port-level checks of the SHA-256 compressor
//
// Watches the message and hash channels and counts accepted words to check that
// stalled hash items hold, new ones start only between blocks and rounds stall input.
// ----------------------------------------------------------------------------
`default_nettype none

module shac_check (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         in_valid,
    input wire logic         in_ready,
    input wire logic         out_valid,
    input wire logic         out_ready,
    input wire logic [255:0] out_data
);

    logic [3:0] word_cnt_reg;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // Position of the next word within its block.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_cnt_reg <= '0;
        end
        else if (in_acc)
        begin
            word_cnt_reg <= word_cnt_reg + 1'b1;
        end
    end

    // A stalled hash item stays valid.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("hash item dropped while stalled");

    // A stalled hash item keeps its words.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("hash words changed while stalled");

    // The input stalls for the rounds once a block's last word is taken.
    a_round_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (word_cnt_reg == 4'd15) |=> !in_ready)
        else $error("word accepted during the rounds");

    // A new hash item appears only at a block boundary.
    a_out_block: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> (word_cnt_reg == 4'd0))
        else $error("hash item inside a block");

    // A hash item taken while words are loading is not followed by another at once.
    a_out_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && in_ready |=> !out_valid)
        else $error("hash item right after the previous one");

endmodule

bind sha256_block_compress shac_check u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (msg.valid),
    .in_ready  (msg.ready),
    .out_valid (hash.valid),
    .out_ready (hash.ready),
    .out_data  ({hash.hash_word7, hash.hash_word6, hash.hash_word5, hash.hash_word4,
                 hash.hash_word3, hash.hash_word2, hash.hash_word1, hash.hash_word0})
);

`default_nettype wire

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for sha256_block_compress
//
// Streams padded message blocks into the compressor and checks every hash
// item against a predictor that tracks the chaining value. The run opens with
// two fixed blocks: the first block after reset without restart, and the
// standard "abc" block with restart. Random blocks follow. Both handshakes see
// random idle cycles, except during one calm window of cycles.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench
    import shac_pkg::*;
();

    localparam int NumRandomBlocks = 48;
    localparam int IdlePercent     = 19;
    localparam int CalmStart       = 1500;
    localparam int CalmEnd         = 2600;
    localparam int DrainCycles     = 100;
    localparam int CycleLimit      = 200000;

    // One message item as the source presents it.
    typedef struct {
        word_t word;
        logic  restart;
    } msg_item_t;

    // SHA-256 initial hash, word 0 first.
    localparam word_t StartHash [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    // SHA-256 round constants.
    localparam word_t RoundConst [64] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    logic clk;
    logic rst_n;

    shac_msg_if  msg_ch ();
    shac_hash_if hash_ch ();

    sha256_block_compress u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .msg   (msg_ch),
        .hash  (hash_ch)
    );

    // Predictor state: chaining value, current block words, word position.
    word_t     chain_state [8];
    word_t     block_words [16];
    logic [3:0] word_pos;

    msg_item_t pending_words [$];
    hash_t     digest_q [$];

    int unsigned cycle_count;
    int unsigned error_count;
    int unsigned words_accepted;
    int unsigned hashes_checked;
    int unsigned restart_blocks;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Rotate right by 1 to 31.
    function automatic word_t rotr(input word_t x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic word_t ep0(input word_t x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t ep1(input word_t x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic word_t mix0(input word_t x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t mix1(input word_t x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    // Takes one accepted message word; on the sixteenth word of a block it
    // compresses the block and queues the updated chaining value.
    task automatic absorb_word(input word_t w, input logic restart);
        word_t sched [64];
        word_t v [8];
        word_t t1;
        word_t t2;
        hash_t digest;
        int    t;
        if (word_pos == 4'd0 && restart)
        begin
            chain_state = StartHash;
            restart_blocks++;
        end
        block_words[word_pos] = w;
        if (word_pos != 4'd15)
        begin
            word_pos = word_pos + 4'd1;
            return;
        end
        word_pos = 4'd0;

        // Message schedule expansion.
        for (t = 0; t < 16; t++)
            sched[t] = block_words[t];
        for (t = 16; t < 64; t++)
            sched[t] = mix1(sched[t - 2]) + sched[t - 7] + mix0(sched[t - 15]) + sched[t - 16];

        // Sixty-four rounds on the working variables.
        v = chain_state;
        for (t = 0; t < 64; t++)
        begin
            t1 = v[7] + ep1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[t] + sched[t];
            t2 = ep0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end

        // Add back into the chaining value and queue the result.
        for (t = 0; t < 8; t++)
        begin
            chain_state[t] = chain_state[t] + v[t];
            digest[t] = chain_state[t];
        end
        digest_q.push_back(digest);
    endtask

    task automatic report_mismatch(input string what);
        $display("ERROR at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    // Random message word, biased toward edge patterns.
    function automatic word_t pick_word();
        int unsigned b;
        b = $urandom_range(31, 0);
        case ($urandom_range(9, 0))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return word_t'(1) << b;
            3: return ~(word_t'(1) << b);
            default: return $urandom;
        endcase
    endfunction

    function automatic bit idle_now();
        if (cycle_count >= CalmStart && cycle_count < CalmEnd)
            return 1'b0;
        return $urandom_range(99, 0) < IdlePercent;
    endfunction

    // Cycle counter and run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("sha256_block_compress test failed");
            $finish;
        end
    end

    // Driver: feeds message items from the pending queue.
    always @(posedge clk or negedge rst_n)
    begin
        msg_item_t item;
        if (!rst_n)
        begin
            msg_ch.valid         <= 1'b0;
            msg_ch.message_word  <= '0;
            msg_ch.restart_chain <= 1'b0;
        end
        else
        begin
            if (msg_ch.valid && msg_ch.ready)
            begin
                absorb_word(msg_ch.message_word, msg_ch.restart_chain);
                words_accepted++;
            end
            if (!msg_ch.valid || msg_ch.ready)
            begin
                if (pending_words.size() > 0 && !idle_now())
                begin
                    item = pending_words.pop_front();
                    msg_ch.valid         <= 1'b1;
                    msg_ch.message_word  <= item.word;
                    msg_ch.restart_chain <= item.restart;
                end
                else
                begin
                    msg_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each hash item against the oldest expected digest.
    always @(posedge clk or negedge rst_n)
    begin
        hash_t want;
        word_t got [8];
        int    i;
        if (!rst_n)
        begin
            hash_ch.ready <= 1'b0;
        end
        else
        begin
            if (hash_ch.valid && hash_ch.ready)
            begin
                if (digest_q.size() == 0)
                begin
                    report_mismatch("hash item with no expected digest");
                end
                else
                begin
                    want = digest_q.pop_front();
                    got = '{hash_ch.hash_word0, hash_ch.hash_word1, hash_ch.hash_word2,
                            hash_ch.hash_word3, hash_ch.hash_word4, hash_ch.hash_word5,
                            hash_ch.hash_word6, hash_ch.hash_word7};
                    for (i = 0; i < 8; i++)
                        if (got[i] !== want[i])
                            report_mismatch($sformatf("hash %0d word%0d: got %08h, want %08h",
                                                      hashes_checked, i, got[i], want[i]));
                    hashes_checked++;
                end
            end
            hash_ch.ready <= !idle_now();
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        msg_item_t item;
        int        blk;
        int        w;

        msg_ch.valid         = 1'b0;
        msg_ch.message_word  = '0;
        msg_ch.restart_chain = 1'b0;
        hash_ch.ready        = 1'b0;
        cycle_count    = 0;
        error_count    = 0;
        words_accepted = 0;
        hashes_checked = 0;
        restart_blocks = 0;
        chain_state    = StartHash;
        word_pos       = 4'd0;
        foreach (block_words[i])
            block_words[i] = '0;

        // First block after reset chains from the reset value; restart flags
        // on words other than the first must be ignored.
        for (w = 0; w < 16; w++)
        begin
            item.word    = 32'hFFFF_FFFF;
            item.restart = (w != 0);
            pending_words.push_back(item);
        end

        // Padded "abc" message with restart.
        for (w = 0; w < 16; w++)
        begin
            item.word    = (w == 0) ? 32'h6162_6380 : (w == 15) ? 32'h0000_0018 : 32'h0;
            item.restart = (w == 0);
            pending_words.push_back(item);
        end

        // Random blocks with random restarts on first words and noise on others.
        for (blk = 0; blk < NumRandomBlocks; blk++)
        begin
            for (w = 0; w < 16; w++)
            begin
                item.word    = pick_word();
                item.restart = 1'($urandom_range(1, 0));
                pending_words.push_back(item);
            end
        end

        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait until every word is taken and every digest is checked.
        while (pending_words.size() > 0 || msg_ch.valid)
            @(negedge clk);
        while (digest_q.size() > 0)
            @(negedge clk);
        repeat (DrainCycles) @(negedge clk);

        if (digest_q.size() > 0)
            report_mismatch($sformatf("%0d expected digests never arrived", digest_q.size()));

        $display("Run covered %0d message words and %0d blocks (%0d with chain restart).",
                 words_accepted, hashes_checked, restart_blocks);
        $display("All eight hash words were checked on every block, %0d errors.", error_count);
        if (error_count == 0)
            $display("sha256_block_compress test passed");
        else
            $display("sha256_block_compress test failed");
        $finish;
    end

endmodule

`default_nettype wire
